// ----- rtl/gpr_pkg.sv -----
// Shared constants for the Gaussian pyramid reduce block.
`timescale 1ns / 1ps
package gpr_pkg;

    // Line memory limit and default parameter value
    localparam int GPR_LINE_CAP       = 1024;
    localparam int DEF_MAX_LINE_WIDTH = 1024;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int WORD_W = 3 * PIX_W;   // oldest, middle, newest line bytes
    localparam int VSUM_W = 11;          // vertical [1 3 3 1] sum, up to 2040
    localparam int RED_W  = 14;
    localparam int OCOL_W = 9;
    localparam int OROW_W = 11;
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int ROW_W  = 12;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Register reset values and limits
    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FW_W-1:0] FW_MIN   = 11'd2;
    localparam logic [FH_W-1:0] FH_MIN   = 13'd2;
    localparam logic [FH_W-1:0] FH_MAX   = 13'd4096;

    localparam logic [RED_W-1:0] RED_MAX = 14'd16320;

endpackage

// ----- rtl/gpr_line_mem.sv -----
// Line memory: one word per column holding the three previous input lines.
`timescale 1ns / 1ps
module gpr_line_mem #(
    parameter int DEPTH = gpr_pkg::GPR_LINE_CAP
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [gpr_pkg::WORD_W-1:0]     rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [gpr_pkg::WORD_W-1:0]     wr_data
);
    import gpr_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/gaussian_pyramid_reduce.sv -----
// Gaussian pyramid reduce: [1 3 3 1]x[1 3 3 1] blur and 2:1 decimation of a pixel stream.
//
// Usage:
//   Pixels enter in raster order on pixel / in_valid / in_ready. Results leave on
//   reduced_pixel, out_column, out_row, end_of_frame with out_valid / out_ready.
//   reduced_pixel is the exact weighted sum, unsigned 8.6 fixed point.
//   An input pixel either completes one reduced pixel or none.
//   Throughput: one pixel per clock while results are taken. Each column is a read-modify-write of one
//   line-memory word (read at accept, written back as the pixel leaves stage 1);
//   a column never repeats within two consecutive pixels, so no forwarding is needed.
//   The pixel that completes a result passes stage 1 (memory read, vertical sum),
//   stage 2 (horizontal sum) and the output register before the result is presented.
//   frame_width (addr 0) and frame_height (addr 4) are written over the APB port
//   while the block is idle; a write restarts the frame at row 0, column 0.
//   Reset: registers go to 640 x 480, position counters and pipeline clear. The
//   line memory needs no clearing: lines above row 0 are masked to zero.
//   When out_ready is low the result holds; one more result and one pixel can wait
//   in the pipeline, after that in_ready drops until the output is taken.
`timescale 1ns / 1ps
module gaussian_pyramid_reduce #(
    parameter int MAX_LINE_WIDTH = gpr_pkg::DEF_MAX_LINE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gpr_pkg::PADDR_W-1:0]   paddr,
    input  logic [gpr_pkg::PDATA_W-1:0]   pwdata,
    output logic [gpr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // pixel input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gpr_pkg::PIX_W-1:0]     pixel,
    // reduced output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gpr_pkg::RED_W-1:0]     reduced_pixel,
    output logic [gpr_pkg::OCOL_W-1:0]    out_column,
    output logic [gpr_pkg::OROW_W-1:0]    out_row,
    output logic                          end_of_frame
);
    import gpr_pkg::*;

    localparam int LINE_LIMIT = (MAX_LINE_WIDTH < GPR_LINE_CAP) ? MAX_LINE_WIDTH : GPR_LINE_CAP;
    localparam int AW = $clog2(LINE_LIMIT);
    localparam logic [FW_W-1:0] W_LIMIT = FW_W'(LINE_LIMIT);

    typedef struct packed {
        logic               emit;
        logic [2:0]         row_ge;   // row >= 3, >= 2, >= 1
        logic               row_b;    // last row of an even-height frame
        logic [2:0]         col_ge;   // column >= 3, >= 2, >= 1
        logic               col_b;    // last column of an even-width frame
        logic [OCOL_W-1:0]  ocol;
        logic [OROW_W-1:0]  orow;
        logic               eof;
    } stage_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            cfg_wr;
    logic            reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamped frame size
    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg < FW_MIN)
            w_eff = FW_MIN;
        else if (frame_width_reg > W_LIMIT)
            w_eff = W_LIMIT;
        else
            w_eff = frame_width_reg;

        if (frame_height_reg < FH_MIN)
            h_eff = FH_MIN;
        else if (frame_height_reg > FH_MAX)
            h_eff = FH_MAX;
        else
            h_eff = frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake across the pipeline
    // ------------------------------------------------------------------
    logic   s1_valid_reg;
    logic   s2_valid_reg;
    logic   out_valid_reg;
    logic   out_free;
    logic   s2_free;
    logic   s2_go;
    logic   s1_adv;
    logic   in_acc;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_go    = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_acc   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Position counters and per-pixel flags
    // ------------------------------------------------------------------
    logic [AW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    col_next;
    logic [ROW_W-1:0] row_next;
    logic [FW_W-1:0]  col_ext;
    logic [FH_W-1:0]  row_ext;
    logic             col_last;
    logic             row_last;
    logic             row_a;
    logic             col_a;
    stage_t           acc_ctl;

    assign col_ext  = FW_W'(col_reg);
    assign row_ext  = FH_W'(row_reg);
    assign col_last = (col_ext == w_eff - 1'b1);
    assign row_last = (row_ext == h_eff - 1'b1);
    assign row_a    = !row_reg[0] && (row_ext >= 13'd2);
    assign col_a    = !col_reg[0] && (col_ext >= 11'd2);

    always_comb
    begin
        acc_ctl.row_b  = !h_eff[0] && row_last;
        acc_ctl.col_b  = !w_eff[0] && col_last;
        acc_ctl.emit   = (row_a || acc_ctl.row_b) && (col_a || acc_ctl.col_b);
        acc_ctl.row_ge = {row_ext >= 13'd3, row_ext >= 13'd2, row_ext >= 13'd1};
        acc_ctl.col_ge = {col_ext >= 11'd3, col_ext >= 11'd2, col_ext >= 11'd1};
        acc_ctl.ocol   = OCOL_W'((col_ext - 1'b1) >> 1);
        acc_ctl.orow   = OROW_W'((row_ext - 1'b1) >> 1);
        acc_ctl.eof    = row_last && col_last;

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line memory read returns; vertical sum and write-back
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;
    logic [AW-1:0]     s1_col_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    stage_t            s1_ctl_reg;
    logic [VSUM_W-1:0] pa;
    logic [VSUM_W-1:0] pb;
    logic [VSUM_W-1:0] pd;
    logic [VSUM_W-1:0] pp;
    logic [VSUM_W-1:0] vsum;

    gpr_line_mem #(
        .DEPTH (LINE_LIMIT)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (rd_word),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word)
    );

    // Lines shift up one slot; the new pixel becomes the newest line
    assign wr_word = {rd_word[2*PIX_W-1:0], s1_px_reg};

    always_comb
    begin
        pa = s1_ctl_reg.row_ge[2] ? VSUM_W'(rd_word[3*PIX_W-1:2*PIX_W]) : '0;
        pb = s1_ctl_reg.row_ge[1] ? VSUM_W'(rd_word[2*PIX_W-1:PIX_W])   : '0;
        pd = s1_ctl_reg.row_ge[0] ? VSUM_W'(rd_word[PIX_W-1:0])         : '0;
        pp = VSUM_W'(s1_px_reg);
        // Below the frame the row after the last one counts as zero
        if (s1_ctl_reg.row_b)
            vsum = pb + (pd << 1) + pd + (pp << 1) + pp;
        else
            vsum = pa + (pb << 1) + pb + (pd << 1) + pd + pp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_col_reg <= col_reg;
            s1_px_reg  <= pixel;
            s1_ctl_reg <= acc_ctl;
        end
    end

    // ------------------------------------------------------------------
    // Column window and stage 2: horizontal sum
    // ------------------------------------------------------------------
    logic [VSUM_W-1:0] win_reg [4];
    stage_t            s2_ctl_reg;
    logic [RED_W-1:0]  h0;
    logic [RED_W-1:0]  h1;
    logic [RED_W-1:0]  h2;
    logic [RED_W-1:0]  h3;
    logic [RED_W-1:0]  hsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= vsum;
            win_reg[1] <= win_reg[0];
            win_reg[2] <= win_reg[1];
            win_reg[3] <= win_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_ctl_reg.emit;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_comb
    begin
        h0 = RED_W'(win_reg[0]);
        h1 = s2_ctl_reg.col_ge[0] ? RED_W'(win_reg[1]) : '0;
        h2 = s2_ctl_reg.col_ge[1] ? RED_W'(win_reg[2]) : '0;
        h3 = s2_ctl_reg.col_ge[2] ? RED_W'(win_reg[3]) : '0;
        if (s2_ctl_reg.col_b)
            hsum = h2 + (h1 << 1) + h1 + (h0 << 1) + h0;
        else
            hsum = h3 + (h2 << 1) + h2 + (h1 << 1) + h1 + h0;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [RED_W-1:0]  red_reg;
    logic [OCOL_W-1:0] ocol_reg;
    logic [OROW_W-1:0] orow_reg;
    logic              eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            red_reg  <= hsum;
            ocol_reg <= s2_ctl_reg.ocol;
            orow_reg <= s2_ctl_reg.orow;
            eof_reg  <= s2_ctl_reg.eof;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reduced_pixel = red_reg;
    assign out_column    = ocol_reg;
    assign out_row       = orow_reg;
    assign end_of_frame  = eof_reg;

endmodule

// ----- rtl/gpr_checker.sv -----
// Port-level checks for the Gaussian pyramid reduce block, bound to the top level.
`timescale 1ns / 1ps
module gpr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pready,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [gpr_pkg::RED_W-1:0]     reduced_pixel,
    input  logic [gpr_pkg::OCOL_W-1:0]    out_column,
    input  logic [gpr_pkg::OROW_W-1:0]    out_row,
    input  logic                          end_of_frame
);
    import gpr_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reduced_pixel)
            && $stable(out_column) && $stable(out_row) && $stable(end_of_frame))
        else $error("result changed while stalled");

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result valid straight out of reset");

    // Weighted sum never exceeds 64 * 255
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reduced_pixel <= RED_MAX)
        else $error("reduced pixel out of range");

    // Register port never inserts wait states
    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("pready low during access");

    // Input backpressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without a stalled result");

endmodule

bind gaussian_pyramid_reduce gpr_checker u_gpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pready        (pready),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reduced_pixel (reduced_pixel),
    .out_column    (out_column),
    .out_row       (out_row),
    .end_of_frame  (end_of_frame)
);
